// ----- hw/rtl/cvg_pkg.sv -----
// ----------------------------------------------------------------------------
// cvg_pkg - chord voice generator shared definitions
// Transaction types, register indexes, gate bit positions and the
// stage-to-stage records of the pipeline.
// ----------------------------------------------------------------------------
package cvg_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_OFFSET    = 2'd0;
   localparam logic [1:0] CSR_INVERSION = 2'd1;
   localparam logic [1:0] CSR_VOICING   = 2'd2;

   localparam logic [12:0] OFFSET_KNOB_RESET    = 13'd2048;
   localparam logic [12:0] INVERSION_KNOB_RESET = 13'd0;
   localparam logic [12:0] VOICING_KNOB_RESET   = 13'd0;

   // Modifier gate bit positions
   localparam int GATE_FLAT3  = 0;
   localparam int GATE_FLAT5  = 1;
   localparam int GATE_FLAT7  = 2;
   localparam int GATE_SUS2   = 3;
   localparam int GATE_SUS4   = 4;
   localparam int GATE_SIX5   = 5;
   localparam int GATE_ONE7   = 6;
   localparam int GATE_FLAT9  = 7;
   localparam int GATE_SHARP9 = 8;
   localparam int GATE_SIX7   = 9;
   localparam int GATE_SHARP5 = 10;

   // Reciprocals scaled by 2^16 for exact floor division of small values
   localparam logic [14:0] RECIP3 = 15'd21846;
   localparam logic [12:0] RECIP9 = 13'd7282;

   typedef enum logic [1:0] {
      INV_ROOT,
      INV_FIRST,
      INV_SECOND,
      INV_THIRD
   } cvg_inv_type;

   typedef enum logic [2:0] {
      VOICE_CLOSE,
      VOICE_DROP2,
      VOICE_DROP3,
      VOICE_DROP24,
      VOICE_SPREAD
   } cvg_voicing_type;

   typedef struct packed {
      logic [12:0] offset_knob;
      logic [12:0] inversion_knob;
      logic [12:0] voicing_knob;
   } cvg_knobs_type;

   typedef struct packed {
      logic signed [15:0] pitch_in;
      logic signed [15:0] offset_cv;
      logic signed [15:0] inversion_cv;
      logic signed [15:0] voicing_cv;
      logic [10:0]        modifier_gates;
   } cvg_req_type;

   typedef struct packed {
      logic signed [15:0] root_out;
      logic signed [15:0] third_out;
      logic signed [15:0] fifth_out;
      logic signed [15:0] seventh_out;
      logic signed [15:0] voice_one;
      logic signed [15:0] voice_two;
      logic signed [15:0] voice_three;
      logic signed [15:0] voice_four;
   } cvg_rsp_type;

   // After stage one: biased magnitudes already scaled down by the
   // power-of-two part of each divisor
   typedef struct packed {
      logic signed [15:0] pitch;
      logic [10:0]        gates;
      logic               oct_neg;
      logic [5:0]         oct_mag;
      logic               semi_neg;
      logic [7:0]         semi_mag;
      logic               inv_neg;
      logic [6:0]         inv_mag;
      logic               vc_neg;
      logic [6:0]         vc_mag;
   } cvg_scaled_type;

   // After stage two: rounded and clamped selectors
   typedef struct packed {
      logic signed [15:0] pitch;
      logic [10:0]        gates;
      logic signed [4:0]  octave;
      logic signed [5:0]  semis;
      cvg_inv_type        inv;
      cvg_voicing_type    vc;
   } cvg_rounded_type;

   // After stage three: chord tones in counts
   typedef struct packed {
      logic signed [18:0] root;
      logic signed [18:0] third;
      logic signed [18:0] fifth;
      logic signed [18:0] seventh;
      logic signed [18:0] alt;
      cvg_inv_type        inv;
      cvg_voicing_type    vc;
   } cvg_chord_type;

endpackage

// ----- hw/rtl/cvg_stage_scale.sv -----
// ----------------------------------------------------------------------------
// cvg_stage_scale - numerator stage
// Forms the selector numerators, takes magnitudes, adds the rounding bias
// and drops the power-of-two part of each divisor.
// ----------------------------------------------------------------------------
module cvg_stage_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  cvg_pkg::cvg_knobs_type  knobs,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  cvg_pkg::cvg_req_type    in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output cvg_pkg::cvg_scaled_type out_data
);
   import cvg_pkg::*;

   logic           valid_ff, valid_in;
   cvg_scaled_type data_ff, data_in;
   logic           stall_up;

   logic signed [16:0] pitch_w;
   logic [16:0]        pitch_abs;
   logic [16:0]        pitch_biased;
   logic signed [19:0] semi_n;
   logic [19:0]        semi_abs;
   logic [19:0]        semi_biased;
   logic signed [18:0] inv_n;
   logic [18:0]        inv_abs;
   logic [18:0]        inv_biased;
   logic signed [20:0] vc_n;
   logic [20:0]        vc_abs;
   logic [20:0]        vc_biased;

   assign stall_up = valid_ff && out_stall;
   assign in_stall = stall_up;

   always_comb begin
      pitch_w      = 17'(in_data.pitch_in);
      pitch_abs    = pitch_w[16] ? 17'(-pitch_w) : 17'(pitch_w);
      pitch_biased = pitch_abs + 17'd1536;

      semi_n = $signed({7'd0, knobs.offset_knob}) * 20'sd27
             + 20'(in_data.offset_cv) * 20'sd2 - 20'sd55296;
      semi_abs    = semi_n[19] ? 20'(-semi_n) : 20'(semi_n);
      semi_biased = semi_abs + 20'd4608;

      inv_n = $signed({6'd0, knobs.inversion_knob}) * 19'sd9
            + 19'(in_data.inversion_cv) - 19'sd9216;
      inv_abs    = inv_n[18] ? 19'(-inv_n) : 19'(inv_n);
      inv_biased = inv_abs + 19'd4608;

      vc_n = $signed({8'd0, knobs.voicing_knob}) * 21'sd45
           + 21'(in_data.voicing_cv) * 21'sd4 - 21'sd73728;
      vc_abs    = vc_n[20] ? 21'(-vc_n) : 21'(vc_n);
      vc_biased = vc_abs + 21'd18432;

      data_in.pitch    = in_data.pitch_in;
      data_in.gates    = in_data.modifier_gates;
      data_in.oct_neg  = pitch_w[16];
      data_in.oct_mag  = pitch_biased[15:10];   // divide by 1024, then by 3
      data_in.semi_neg = semi_n[19];
      data_in.semi_mag = semi_biased[17:10];    // divide by 1024, then by 9
      data_in.inv_neg  = inv_n[18];
      data_in.inv_mag  = inv_biased[16:10];     // divide by 1024, then by 9
      data_in.vc_neg   = vc_n[20];
      data_in.vc_mag   = vc_biased[18:12];      // divide by 4096, then by 9

      valid_in = stall_up ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !stall_up) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hw/rtl/cvg_stage_round.sv -----
// ----------------------------------------------------------------------------
// cvg_stage_round - quotient stage
// Finishes each division by reciprocal multiplication, restores the sign
// and clamps the inversion and voicing selectors.
// ----------------------------------------------------------------------------
module cvg_stage_round (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  cvg_pkg::cvg_scaled_type  in_data,
   output logic                     out_valid,
   input  logic                     out_stall,
   output cvg_pkg::cvg_rounded_type out_data
);
   import cvg_pkg::*;

   logic            valid_ff, valid_in;
   cvg_rounded_type data_ff, data_in;
   logic            stall_up;

   logic [20:0] oct_prod;
   logic [20:0] semi_prod;
   logic [19:0] inv_prod;
   logic [19:0] vc_prod;
   logic [4:0]  oct_q;
   logic [4:0]  semi_q;
   logic [3:0]  inv_q;
   logic [3:0]  vc_q;

   assign stall_up = valid_ff && out_stall;
   assign in_stall = stall_up;

   always_comb begin
      oct_prod  = 21'(in_data.oct_mag) * 21'(RECIP3);
      semi_prod = 21'(in_data.semi_mag) * 21'(RECIP9);
      inv_prod  = 20'(in_data.inv_mag) * 20'(RECIP9);
      vc_prod   = 20'(in_data.vc_mag) * 20'(RECIP9);
      oct_q     = oct_prod[20:16];
      semi_q    = semi_prod[20:16];
      inv_q     = inv_prod[19:16];
      vc_q      = vc_prod[19:16];

      data_in.pitch  = in_data.pitch;
      data_in.gates  = in_data.gates;
      data_in.octave = in_data.oct_neg ? -$signed(oct_q) : $signed(oct_q);
      data_in.semis  = in_data.semi_neg ? -$signed({1'b0, semi_q})
                                        : $signed({1'b0, semi_q});

      // clamp inversion to -1..2
      if (in_data.inv_neg && (inv_q != 4'd0)) begin
         data_in.inv = INV_ROOT;
      end else if (inv_q == 4'd0) begin
         data_in.inv = INV_FIRST;
      end else if (inv_q == 4'd1) begin
         data_in.inv = INV_SECOND;
      end else begin
         data_in.inv = INV_THIRD;
      end

      // clamp voicing to -2..2
      if (in_data.vc_neg && (vc_q >= 4'd2)) begin
         data_in.vc = VOICE_CLOSE;
      end else if (in_data.vc_neg && (vc_q == 4'd1)) begin
         data_in.vc = VOICE_DROP2;
      end else if (vc_q == 4'd0) begin
         data_in.vc = VOICE_DROP3;
      end else if (vc_q == 4'd1) begin
         data_in.vc = VOICE_DROP24;
      end else begin
         data_in.vc = VOICE_SPREAD;
      end

      valid_in = stall_up ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !stall_up) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hw/rtl/cvg_stage_chord.sv -----
// ----------------------------------------------------------------------------
// cvg_stage_chord - chord tone stage
// Folds the pitch into its octave, transposes it and builds the chord
// tones from the modifier gates.
// ----------------------------------------------------------------------------
module cvg_stage_chord (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  cvg_pkg::cvg_rounded_type in_data,
   output logic                     out_valid,
   input  logic                     out_stall,
   output cvg_pkg::cvg_chord_type   out_data
);
   import cvg_pkg::*;

   logic          valid_ff, valid_in;
   cvg_chord_type data_ff, data_in;
   logic          stall_up;

   logic signed [17:0] root;
   logic [3:0]         third_semi;
   logic [3:0]         fifth_semi;
   logic [3:0]         seventh_semi;
   logic [1:0]         alt_semi;

   assign stall_up = valid_ff && out_stall;
   assign in_stall = stall_up;

   always_comb begin
      root = 18'(in_data.pitch) - 18'(in_data.octave) * 18'sd3072
           + 18'(in_data.semis) * 18'sd256;

      // later rules win
      third_semi   = 4'd4;
      fifth_semi   = 4'd7;
      seventh_semi = 4'd11;
      alt_semi     = 2'd0;
      if (in_data.gates[GATE_FLAT3])  third_semi   = 4'd3;
      if (in_data.gates[GATE_FLAT5])  fifth_semi   = 4'd6;
      if (in_data.gates[GATE_SHARP5]) fifth_semi   = 4'd8;
      if (in_data.gates[GATE_FLAT7])  seventh_semi = 4'd10;
      if (in_data.gates[GATE_SUS2])   alt_semi     = 2'd2;
      if (in_data.gates[GATE_SUS4])   third_semi   = 4'd5;
      if (in_data.gates[GATE_SIX5])   fifth_semi   = 4'd9;
      if (in_data.gates[GATE_SIX7])   seventh_semi = 4'd9;
      if (in_data.gates[GATE_FLAT9])  alt_semi     = 2'd1;
      if (in_data.gates[GATE_SHARP9]) alt_semi     = 2'd3;
      if (in_data.gates[GATE_ONE7])   seventh_semi = 4'd12;

      data_in.root    = 19'(root);
      data_in.third   = 19'(root) + $signed({7'd0, third_semi, 8'd0});
      data_in.fifth   = 19'(root) + $signed({7'd0, fifth_semi, 8'd0});
      data_in.seventh = 19'(root) + $signed({7'd0, seventh_semi, 8'd0});
      data_in.alt     = 19'(root) + $signed({9'd0, alt_semi, 8'd0});
      data_in.inv     = in_data.inv;
      data_in.vc      = in_data.vc;

      valid_in = stall_up ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !stall_up) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hw/rtl/cvg_stage_voice.sv -----
// ----------------------------------------------------------------------------
// cvg_stage_voice - voice placement and output stage
// Orders the voices by inversion, shifts octaves by voicing and saturates
// every pitch into the output register.
// ----------------------------------------------------------------------------
module cvg_stage_voice (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  cvg_pkg::cvg_chord_type in_data,
   output logic                   out_valid,
   input  logic                   out_stall,
   output cvg_pkg::cvg_rsp_type   out_data
);
   import cvg_pkg::*;

   localparam logic signed [19:0] OCTAVE = 20'sd3072;

   logic        valid_ff, valid_in;
   cvg_rsp_type data_ff, data_in;
   logic        stall_up;

   logic signed [19:0] a, t, f, s;
   logic signed [19:0] v1, v2, v3, v4;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign stall_up = valid_ff && out_stall;
   assign in_stall = stall_up;

   always_comb begin
      a = 20'(in_data.alt);
      t = 20'(in_data.third);
      f = 20'(in_data.fifth);
      s = 20'(in_data.seventh);

      case (in_data.inv)
         INV_ROOT: begin
            v1 = a; v2 = t; v3 = f; v4 = s;
         end
         INV_FIRST: begin
            v1 = t; v2 = f; v3 = s; v4 = a + OCTAVE;
         end
         INV_SECOND: begin
            v1 = f; v2 = s; v3 = a + OCTAVE; v4 = t + OCTAVE;
         end
         default: begin
            v1 = s; v2 = a + OCTAVE; v3 = t + OCTAVE; v4 = f + OCTAVE;
         end
      endcase

      case (in_data.vc)
         VOICE_CLOSE: begin
         end
         VOICE_DROP2: begin
            v2 = v2 - OCTAVE;
         end
         VOICE_DROP3: begin
            v3 = v3 - OCTAVE;
         end
         VOICE_DROP24: begin
            v2 = v2 - OCTAVE;
            v4 = v4 - OCTAVE;
         end
         VOICE_SPREAD: begin
            v2 = v2 + OCTAVE;
            v4 = v4 + OCTAVE;
         end
         default: begin
         end
      endcase

      data_in.root_out    = sat16(20'(in_data.root));
      data_in.third_out   = sat16(t);
      data_in.fifth_out   = sat16(f);
      data_in.seventh_out = sat16(s);
      data_in.voice_one   = sat16(v1);
      data_in.voice_two   = sat16(v2);
      data_in.voice_three = sat16(v3);
      data_in.voice_four  = sat16(v4);

      valid_in = stall_up ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !stall_up) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hw/rtl/chord_voice_generator.sv -----
// ----------------------------------------------------------------------------
// chord_voice_generator - four-voice chord builder from a 1 V/oct pitch
// Turns one pitch transaction with offset, inversion and voicing controls
// and chord-modifier gates into root, third, fifth, seventh and four voices.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  input channel, valid/stall. A transaction is taken on a rising
//          edge with req_valid high and req_stall low.
//   rsp_*  result channel, valid/stall. Exactly one result leaves for each
//          request, in request order.
//   csr_*  register writes (index 0 offset, 1 inversion, 2 voicing knob);
//          csr_ready is always high and writes to index 3 are dropped.
//          Write only while the pipeline holds no transaction.
// Pipeline: an accepted transaction passes one register stage each
//   (numerator, quotient, chord tones, voice placement/output) to rsp_valid.
// Throughput: one transaction per cycle unless stalled; each stage register
//   holds one transaction, so the rate is set by the four-stage pipeline alone.
// Stall: a stalled result holds in the output register; earlier stages
//   keep filling empty slots, and req_stall rises only once every stage
//   is occupied behind a stalled output.
// Reset: synchronous; empties the pipeline and loads the knob defaults
//   (offset 2048, inversion 0, voicing 0).
// ----------------------------------------------------------------------------
module chord_voice_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cvg_pkg::cvg_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cvg_pkg::cvg_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [12:0]          csr_data
);
   import cvg_pkg::*;

   cvg_knobs_type   knobs_ff, knobs_in;

   logic            s1_valid, s1_stall;
   cvg_scaled_type  s1_data;
   logic            s2_valid, s2_stall;
   cvg_rounded_type s2_data;
   logic            s3_valid, s3_stall;
   cvg_chord_type   s3_data;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      knobs_in = knobs_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET:    knobs_in.offset_knob    = csr_data;
            CSR_INVERSION: knobs_in.inversion_knob = csr_data;
            CSR_VOICING:   knobs_in.voicing_knob   = csr_data;
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         knobs_ff.offset_knob    <= OFFSET_KNOB_RESET;
         knobs_ff.inversion_knob <= INVERSION_KNOB_RESET;
         knobs_ff.voicing_knob   <= VOICING_KNOB_RESET;
      end else begin
         knobs_ff <= knobs_in;
      end
   end

   // Stage one: numerators, magnitudes and rounding bias
   cvg_stage_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .knobs     (knobs_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .out_data  (s1_data)
   );

   // Stage two: quotients and selector clamps
   cvg_stage_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_data  (s2_data)
   );

   // Stage three: root and chord tones
   cvg_stage_chord u_chord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_stall (s3_stall),
      .out_data  (s3_data)
   );

   // Stage four: voice placement, saturation, output register
   cvg_stage_voice u_voice (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_stall  (s3_stall),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/cvg_checker.sv -----
// ----------------------------------------------------------------------------
// cvg_checker - port-level checks for the chord voice generator
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module cvg_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cvg_pkg::cvg_rsp_type rsp_data
);
   import cvg_pkg::*;

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Back-pressure on the input only comes from a stalled output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // An accepted request reaches rsp_valid when the output keeps draining
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("result missing four cycles after acceptance");

endmodule

bind chord_voice_generator cvg_checker u_cvg_checker (.*);
